FILE: hdl/khc_pkg.sv
`default_nettype none

package khc_pkg;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	localparam int OPCODE_W    = 2;
	localparam int CHAR_W      = 8;
	localparam int INDEX_W     = 14;
	localparam int COUNT_OUT_W = 32;
	localparam int KLEN_W      = 3;
	localparam int DIGIT_W     = 3;

	localparam logic [KLEN_W-1:0] KLEN_RESET = 3'd3;

	typedef logic [DIGIT_W-1:0] digit_t;

	localparam digit_t DIGIT_A     = 3'd0;
	localparam digit_t DIGIT_C     = 3'd1;
	localparam digit_t DIGIT_G     = 3'd2;
	localparam digit_t DIGIT_T     = 3'd3;
	localparam digit_t DIGIT_OTHER = 3'd4;

	localparam int unsigned DIGIT_BASE = 5;

	function automatic digit_t letter_digit(input logic [CHAR_W-1:0] ch);
		digit_t d;
		unique case (ch) inside
			8'h41, 8'h61:               d = DIGIT_A;
			8'h43, 8'h63:               d = DIGIT_C;
			8'h47, 8'h67:               d = DIGIT_G;
			8'h54, 8'h74, 8'h55, 8'h75: d = DIGIT_T;
			default:                    d = DIGIT_OTHER;
		endcase
		return d;
	endfunction

	// elaboration-time power of the digit base
	function automatic int unsigned pow5(input int unsigned e);
		int unsigned p;
		p = 1;
		for (int unsigned i = 0; i < e; i++) begin
			p = p * DIGIT_BASE;
		end
		return p;
	endfunction

	typedef struct packed {
		logic roll_step;
		logic seq_clear;
		logic rd_en;
		logic rd_sel_read;
		logic wr_incr;
		logic sweep_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic push_hit;
		logic sweep_last;
		logic out_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/khc_ram.sv
`default_nettype none

module khc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 15625
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/khc_ctrl.sv
`default_nettype none

module khc_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic [khc_pkg::OPCODE_W-1:0] opcode,
	output logic                             in_ready,
	input  wire khc_pkg::dp_stat_t           stat,
	output khc_pkg::dp_cmd_t                 cmd
);

	import khc_pkg::*;

	typedef enum logic [3:0] {
		ST_SWEEP = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_INC   = 4'b0100,
		ST_RDATA = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (opcode_t'(opcode))
						OP_PUSH: begin
							cmd.roll_step = 1'b1;
							if (stat.push_hit) begin
								cmd.rd_en = 1'b1;
								state_nx  = ST_INC;
							end
						end
						OP_READ: begin
							cmd.rd_en       = 1'b1;
							cmd.rd_sel_read = 1'b1;
							state_nx        = ST_RDATA;
						end
						OP_CLEAR: begin
							cmd.seq_clear = 1'b1;
							state_nx      = ST_SWEEP;
						end
						OP_NONE: begin
						end
						default: begin
						end
					endcase
				end
			end
			ST_INC: begin
				cmd.wr_incr = 1'b1;
				state_nx    = ST_IDLE;
			end
			ST_RDATA: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_SWEEP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/khc_dp.sv
`default_nettype none

module khc_dp #(
	parameter int MAX_KMER    = 6,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [khc_pkg::KLEN_W-1:0]     cfg_data,
	input  wire logic [khc_pkg::CHAR_W-1:0]     char_code,
	input  wire logic [khc_pkg::INDEX_W-1:0]    read_index,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output logic      [khc_pkg::COUNT_OUT_W-1:0] count_value,
	output logic      [khc_pkg::INDEX_W-1:0]    index_echo,
	input  wire khc_pkg::dp_cmd_t               cmd,
	output khc_pkg::dp_stat_t                   stat
);

	import khc_pkg::*;

	localparam int unsigned DEPTH = pow5(MAX_KMER);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int FILL_W = $clog2(MAX_KMER + 1);
	localparam int IW     = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;

	logic [KLEN_W-1:0]                 klen_q;
	logic [FILL_W-1:0]                 k_eff;
	logic [FILL_W-1:0]                 fill_q;
	logic [FILL_W-1:0]                 fill_inc;
	logic [MAX_KMER:1][ADDR_W-1:0]     roll_q;
	logic [MAX_KMER:1][ADDR_W-1:0]     roll_nx;
	digit_t                            digit;
	logic [ADDR_W-1:0]                 addr_q;
	logic [ADDR_W-1:0]                 sweep_q;
	logic [IW-1:0]                     idx_wide;
	logic                              rd_zero_q;
	logic [INDEX_W-1:0]                rd_echo_q;
	logic [ADDR_W-1:0]                 raddr;
	logic [ADDR_W-1:0]                 waddr;
	logic [COUNT_WIDTH-1:0]            wdata;
	logic [COUNT_WIDTH-1:0]            rdata;
	logic                              we;
	logic [COUNT_OUT_W-1:0]            rd_clip;
	logic                              out_valid_q;
	logic [COUNT_OUT_W-1:0]            count_q;
	logic [INDEX_W-1:0]                echo_q;

	assign digit = letter_digit(char_code);

	always_comb begin
		if (klen_q == '0) begin
			k_eff = FILL_W'(1);
		end else if (int'(klen_q) > MAX_KMER) begin
			k_eff = FILL_W'(MAX_KMER);
		end else begin
			k_eff = FILL_W'(klen_q);
		end
	end

	assign fill_inc = (fill_q == FILL_W'(MAX_KMER)) ? fill_q : fill_q + FILL_W'(1);

	// one lane per k: drop the oldest digit, shift in the new one
	for (genvar g = 1; g <= MAX_KMER; g++) begin : g_lane
		localparam int unsigned P = pow5(g - 1);
		logic [ADDR_W-1:0] low;
		always_comb begin
			if (roll_q[g] >= ADDR_W'(4 * P)) begin
				low = roll_q[g] - ADDR_W'(4 * P);
			end else if (roll_q[g] >= ADDR_W'(3 * P)) begin
				low = roll_q[g] - ADDR_W'(3 * P);
			end else if (roll_q[g] >= ADDR_W'(2 * P)) begin
				low = roll_q[g] - ADDR_W'(2 * P);
			end else if (roll_q[g] >= ADDR_W'(P)) begin
				low = roll_q[g] - ADDR_W'(P);
			end else begin
				low = roll_q[g];
			end
		end
		assign roll_nx[g] = (low << 2) + low + ADDR_W'(digit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= KLEN_RESET;
			fill_q <= '0;
			roll_q <= '0;
		end else begin
			if (cfg_valid) begin
				klen_q <= cfg_data;
			end
			if (cmd.seq_clear) begin
				fill_q <= '0;
				roll_q <= '0;
			end else if (cmd.roll_step) begin
				fill_q <= fill_inc;
				roll_q <= roll_nx;
			end
		end
	end

	assign idx_wide = IW'(read_index);
	assign raddr    = cmd.rd_sel_read ? idx_wide[ADDR_W-1:0] : roll_nx[k_eff];

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			addr_q    <= raddr;
			rd_zero_q <= (idx_wide >= IW'(DEPTH));
			rd_echo_q <= read_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_step) begin
			sweep_q <= (sweep_q == ADDR_W'(DEPTH - 1)) ? '0 : sweep_q + ADDR_W'(1);
		end
	end

	assign we    = cmd.wr_incr | cmd.sweep_step;
	assign waddr = cmd.sweep_step ? sweep_q : addr_q;
	assign wdata = cmd.sweep_step ? '0 : ((&rdata) ? rdata : rdata + COUNT_WIDTH'(1));

	khc_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	if (COUNT_WIDTH > COUNT_OUT_W) begin : g_clip
		assign rd_clip = (|rdata[COUNT_WIDTH-1:COUNT_OUT_W]) ? '1 : rdata[COUNT_OUT_W-1:0];
	end else begin : g_ext
		assign rd_clip = COUNT_OUT_W'(rdata);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			count_q <= rd_zero_q ? '0 : rd_clip;
			echo_q  <= rd_echo_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign count_value = count_q;
	assign index_echo  = echo_q;

	assign stat.push_hit   = (fill_inc >= k_eff);
	assign stat.sweep_last = (sweep_q == ADDR_W'(DEPTH - 1));
	assign stat.out_busy   = out_valid_q & ~out_ready;

endmodule

`default_nettype wire

FILE: hdl/kmer_histogram_counter.sv
`default_nettype none

// K-mer histogram over a nucleotide stream. Each pushed byte maps to a base-5
// digit (A=0 C=1 G=2 T/U=3, other=4, either case); once k bytes of the current
// sequence are in, the saturating counter for the last k digits is bumped.
// The table lives in one RAM of 5^MAX_KMER words, so a push that counts does a
// table read, then an increment write, and a push before k bytes does neither.
// A read does a table read, then loads the output register; further items are taken
// while a result waits there, and a read only stalls if the previous result is
// still untaken. A clear, and likewise reset, runs a zeroing sweep over all
// 5^MAX_KMER words (15625 by default) with in_ready low; cfg transfers are
// accepted at any time. Read indexes at or above 5^MAX_KMER return a count of 0.
module kmer_histogram_counter #(
	parameter int MAX_KMER    = 6,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [khc_pkg::KLEN_W-1:0]      cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [khc_pkg::OPCODE_W-1:0]    opcode,
	input  wire logic [khc_pkg::CHAR_W-1:0]      char_code,
	input  wire logic [khc_pkg::INDEX_W-1:0]     read_index,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [khc_pkg::COUNT_OUT_W-1:0] count_value,
	output logic      [khc_pkg::INDEX_W-1:0]     index_echo
);

	import khc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	khc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.opcode  (opcode),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	khc_dp #(
		.MAX_KMER   (MAX_KMER),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.char_code  (char_code),
		.read_index (read_index),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.count_value(count_value),
		.index_echo (index_echo),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;
	import khc_pkg::*;

	localparam int          MAX_K         = 6;
	localparam int unsigned TBL_DEPTH     = 15625;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          HOLD_CYCLES   = 300;
	localparam int unsigned STALL_LIMIT   = 100000;

	typedef struct {
		logic [COUNT_OUT_W-1:0] count;
		logic [INDEX_W-1:0]     index;
	} read_result_t;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   cfg_valid  = 1'b0;
	logic                   cfg_ready;
	logic [KLEN_W-1:0]      cfg_data   = '0;
	logic                   in_valid   = 1'b0;
	logic                   in_ready;
	logic [OPCODE_W-1:0]    opcode     = '0;
	logic [CHAR_W-1:0]      char_code  = '0;
	logic [INDEX_W-1:0]     read_index = '0;
	logic                   out_valid;
	logic                   out_ready  = 1'b0;
	logic [COUNT_OUT_W-1:0] count_value;
	logic [INDEX_W-1:0]     index_echo;

	// histogram shadow state
	logic [COUNT_OUT_W-1:0] kmer_counts [int unsigned];
	int unsigned            roll_idx     = 0;
	int unsigned            fill_cnt     = 0;
	logic [KLEN_W-1:0]      kmer_len_cfg = KLEN_RESET;
	int unsigned            last_addr    = 0;
	read_result_t           expected_counts [$];

	int          mismatch_count = 0;
	bit          src_idle       = 1'b1;
	bit          sink_idle      = 1'b1;
	bit          hold_req       = 1'b0;
	int unsigned hold_left      = 0;
	int unsigned sink_gap       = 0;

	kmer_histogram_counter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.char_code  (char_code),
		.read_index (read_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.count_value(count_value),
		.index_echo (index_echo)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic digit_t base_digit(input logic [CHAR_W-1:0] ch);
		case (ch)
			"A", "a":           return DIGIT_A;
			"C", "c":           return DIGIT_C;
			"G", "g":           return DIGIT_G;
			"T", "t", "U", "u": return DIGIT_T;
			default:            return DIGIT_OTHER;
		endcase
	endfunction

	function automatic int unsigned active_k();
		if (kmer_len_cfg < 1) begin
			return 1;
		end
		if (kmer_len_cfg > MAX_K) begin
			return MAX_K;
		end
		return kmer_len_cfg;
	endfunction

	function automatic int unsigned kmer_span(input int unsigned k);
		int unsigned p;
		p = 1;
		for (int unsigned i = 0; i < k; i++) begin
			p = p * DIGIT_BASE;
		end
		return p;
	endfunction

	task automatic update_histogram(input opcode_t op, input logic [CHAR_W-1:0] ch,
			input logic [INDEX_W-1:0] idx);
		int unsigned  k;
		int unsigned  addr;
		read_result_t r;
		case (op)
			OP_PUSH: begin
				k = active_k();
				roll_idx = (roll_idx * DIGIT_BASE + base_digit(ch)) % TBL_DEPTH;
				if (fill_cnt < MAX_K) begin
					fill_cnt++;
				end
				if (fill_cnt >= k) begin
					addr = roll_idx % kmer_span(k);
					if (!kmer_counts.exists(addr)) begin
						kmer_counts[addr] = '0;
					end
					if (kmer_counts[addr] != '1) begin
						kmer_counts[addr] = kmer_counts[addr] + 1'b1;
					end
					last_addr = addr;
				end
			end
			OP_READ: begin
				r.index = idx;
				r.count = '0;
				if (idx < TBL_DEPTH && kmer_counts.exists(idx)) begin
					r.count = kmer_counts[idx];
				end
				expected_counts.push_back(r);
			end
			OP_CLEAR: begin
				kmer_counts.delete();
				roll_idx = 0;
				fill_cnt = 0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_count(input logic [COUNT_OUT_W-1:0] got_count,
			input logic [INDEX_W-1:0] got_index);
		read_result_t want;
		if (expected_counts.size() == 0) begin
			report_mismatch($sformatf("unexpected result count=%0d index=%0d",
				got_count, got_index));
		end else begin
			want = expected_counts.pop_front();
			if (got_count !== want.count) begin
				report_mismatch($sformatf("count_value %0d, want %0d (index %0d)",
					got_count, want.count, want.index));
			end
			if (got_index !== want.index) begin
				report_mismatch($sformatf("index_echo %0d, want %0d", got_index, want.index));
			end
		end
	endtask

	// result sink: checks each transfer, draws stall cycles, honors long holds
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			check_count(count_value, index_echo);
			sink_gap = sink_idle ? $urandom_range(0, 4) : 0;
		end else if (sink_gap > 0) begin
			sink_gap--;
		end
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left--;
		end
		out_ready <= (sink_gap == 0) && (hold_left == 0);
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("kmer_histogram_counter: mismatch");
		$finish;
	end

	task automatic offer_item(input opcode_t op, input logic [CHAR_W-1:0] ch,
			input logic [INDEX_W-1:0] idx);
		int gap;
		gap = src_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		char_code  <= ch;
		read_index <= idx;
		do @(posedge clk); while (!in_ready);
		update_histogram(op, ch, idx);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (expected_counts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic set_kmer_length(input logic [KLEN_W-1:0] value);
		wait_results_done();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		kmer_len_cfg = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CHAR_W-1:0] pick_char();
		case ($urandom_range(0, 11))
			0:       return "A";
			1:       return "C";
			2:       return "G";
			3:       return "T";
			4:       return "U";
			5:       return "a";
			6:       return "c";
			7:       return "g";
			8:       return "t";
			9:       return "u";
			default: return CHAR_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [INDEX_W-1:0] pick_index();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel == 0) begin
			return INDEX_W'($urandom_range(TBL_DEPTH, (1 << INDEX_W) - 1));
		end
		if (sel < 4) begin
			return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
		end
		if (sel < 11) begin
			return INDEX_W'($urandom_range(0, kmer_span(active_k()) - 1));
		end
		return INDEX_W'(last_addr);
	endfunction

	task automatic random_item();
		int unsigned roll;
		opcode_t     op;
		roll = $urandom_range(0, 999);
		if (roll < 8) begin
			op = OP_CLEAR;
		end else if (roll < 40) begin
			op = OP_NONE;
		end else if (roll < 300) begin
			op = OP_READ;
		end else begin
			op = OP_PUSH;
		end
		offer_item(op, pick_char(), pick_index());
	endtask

	task automatic test_directed();
		offer_item(OP_READ, "A", 14'd0);
		offer_item(OP_PUSH, "A", 14'd0);
		offer_item(OP_PUSH, "C", 14'd0);
		offer_item(OP_PUSH, "G", 14'd0);
		offer_item(OP_READ, "A", 14'd7);
		offer_item(OP_PUSH, "T", 14'd0);
		offer_item(OP_PUSH, "u", 14'd0);
		offer_item(OP_PUSH, "a", 14'd0);
		offer_item(OP_PUSH, "c", 14'd0);
		offer_item(OP_PUSH, "g", 14'd0);
		offer_item(OP_PUSH, "t", 14'd0);
		offer_item(OP_PUSH, "U", 14'd0);
		offer_item(OP_PUSH, 8'hFF, 14'd0);
		offer_item(OP_PUSH, 8'h00, 14'd0);
		offer_item(OP_READ, 8'h00, 14'd99);
		offer_item(OP_READ, 8'hFF, 14'd124);
		// ignored opcode must not push
		offer_item(OP_NONE, "A", 14'd7);
		offer_item(OP_READ, "A", 14'd15624);
		offer_item(OP_READ, "A", 14'd15625);
		offer_item(OP_READ, "A", 14'h3FFF);
		offer_item(OP_CLEAR, "A", 14'd0);
		offer_item(OP_READ, "A", 14'd99);
	endtask

	task automatic test_k_change_mid_sequence();
		set_kmer_length(3'd6);
		offer_item(OP_PUSH, "G", 14'd0);
		offer_item(OP_PUSH, "T", 14'd0);
		offer_item(OP_PUSH, "C", 14'd0);
		set_kmer_length(3'd2);
		offer_item(OP_PUSH, "A", 14'd0);
		offer_item(OP_PUSH, "G", 14'd0);
		offer_item(OP_READ, "A", INDEX_W'(last_addr));
		set_kmer_length(3'd5);
		offer_item(OP_PUSH, "t", 14'd0);
		offer_item(OP_READ, "A", INDEX_W'(last_addr));
		offer_item(OP_READ, "A", 14'd0);
	endtask

	task automatic test_kmer_settings();
		logic [KLEN_W-1:0] k_order [8];
		k_order = '{3'd1, 3'd6, 3'd0, 3'd7, 3'd2, 3'd4, 3'd5, 3'd3};
		foreach (k_order[s]) begin
			set_kmer_length(k_order[s]);
			src_idle  = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			repeat (130) random_item();
		end
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	task automatic test_backpressure();
		wait_results_done();
		src_idle = 1'b0;
		hold_req = 1'b1;
		repeat (40) begin
			offer_item(($urandom_range(0, 3) == 0) ? OP_PUSH : OP_READ, pick_char(), pick_index());
		end
		src_idle = 1'b1;
	endtask

	task automatic test_source_pause();
		repeat (6) begin
			repeat (15) random_item();
			wait_results_done();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_k_change_mid_sequence();
		test_kmer_settings();
		test_backpressure();
		test_source_pause();
		repeat (120) random_item();
		wait_results_done();
		if (mismatch_count == 0) begin
			$display("kmer_histogram_counter: match");
		end else begin
			$display("kmer_histogram_counter: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/khc_pkg.sv
hdl/khc_ram.sv
hdl/khc_ctrl.sv
hdl/khc_dp.sv
hdl/kmer_histogram_counter.sv
tb/tb.sv
